### src/counter_priority_task_scheduler_core_macros.svh
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Shared concurrent assertion forms for the scheduler checker.
// ----------------------------------------------------------------------------
`ifndef COUNTER_PRIORITY_TASK_SCHEDULER_CORE_MACROS_SVH
`define COUNTER_PRIORITY_TASK_SCHEDULER_CORE_MACROS_SVH

// The condition must never hold at a clock edge outside reset.
`define CPTS_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("scheduler check failed: forbidden condition seen");

// The antecedent implies the consequent in the same cycle.
`define CPTS_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed: implication violated");

// The antecedent implies the consequent in the following cycle.
`define CPTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed: next-cycle implication violated");

`endif

### src/cpts_pkg.sv
// ----------------------------------------------------------------------------
// Scheduler package
// Types, codes and constants shared by the scheduler modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package cpts_pkg;

    localparam int TASK_SLOTS = 16;
    localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam logic [9:0] MS_PER_SECOND = 10'd1000;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_SLEEP  = 3'd1,
        OP_CREATE = 3'd2,
        OP_EXIT   = 3'd3,
        OP_SCHED  = 3'd4
    } op_e;

    typedef enum logic [1:0] {
        ST_RUNNING  = 2'd0,
        ST_SLEEPING = 2'd1,
        ST_EXITED   = 2'd2
    } slot_status_e;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OP,
        S_SCAN,
        S_DECIDE,
        S_RECHARGE,
        S_FINISH
    } state_e;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] now_ms;
        logic [15:0] sleep_seconds;
        logic [3:0]  slot_index;
        logic [6:0]  slot_priority;
    } in_item_t;

    typedef struct packed {
        logic       scheduled;
        logic       switched;
        logic [3:0] chosen_slot;
        logic [3:0] current_slot;
    } out_result_t;

    typedef struct packed {
        logic load;
        logic do_op;
        logic clear;
        logic scan;
        logic recharge;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic run_sel;
        logic scan_last;
        logic need_recharge;
    } ctrl_status_t;

endpackage

### src/cpts_ctrl.sv
// ----------------------------------------------------------------------------
// Scheduler controller
// State machine that sequences the operation, scan and recharge passes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module cpts_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  cpts_pkg::ctrl_status_t stat,
    output cpts_pkg::ctrl_cmd_t    cmd
);
    import cpts_pkg::*;

    state_e state_reg;
    state_e state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_OP;
                end
            end
            S_OP:
            begin
                state_next = stat.run_sel ? S_SCAN : S_FINISH;
            end
            S_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = stat.need_recharge ? S_RECHARGE : S_FINISH;
            end
            S_RECHARGE:
            begin
                if (stat.scan_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        busy = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                cmd.load = start;
            end
            S_OP:
            begin
                cmd.do_op = 1'b1;
                cmd.clear = 1'b1;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            S_DECIDE:
            begin
                cmd.clear = stat.need_recharge;
            end
            S_RECHARGE:
            begin
                cmd.scan = 1'b1;
                cmd.recharge = 1'b1;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

### src/cpts_datapath.sv
// ----------------------------------------------------------------------------
// Scheduler datapath
// Slot table, operation logic, scan unit for wake-up, selection and recharge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module cpts_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cpts_pkg::in_item_t     item,
    input  cpts_pkg::ctrl_cmd_t    cmd,
    output cpts_pkg::ctrl_status_t stat,
    output logic                   done,
    output cpts_pkg::out_result_t  result
);
    import cpts_pkg::*;

    in_item_t            item_reg;
    logic [TASK_SLOTS-1:0] present_reg;
    slot_status_e        status_reg [TASK_SLOTS];
    logic [7:0]          counter_reg [TASK_SLOTS];
    logic [6:0]          prio_reg [TASK_SLOTS];
    logic [31:0]         wake_reg [TASK_SLOTS];
    logic [SLOT_W-1:0]   running_reg;
    logic [SLOT_W-1:0]   scan_reg;
    logic                pick_valid_reg;
    logic [SLOT_W-1:0]   pick_reg;
    logic [7:0]          top_reg;
    logic                run_sel_reg;
    logic                done_reg;
    out_result_t         result_reg;

    logic [SLOT_W-1:0]   cur;
    logic                cur_present;
    logic [SLOT_W-1:0]   idx;
    logic                idx_ok;
    logic [6:0]          prio_fix;
    logic [31:0]         wake_new;
    logic                op_run_sel;
    logic                woke;
    slot_status_e        eff_status;
    logic [7:0]          cnt_eff;
    logic                cand;
    logic [SLOT_W-1:0]   final_pick;
    logic                final_sw;

    assign cur = running_reg;
    assign cur_present = present_reg[cur];
    assign idx = SLOT_W'(item_reg.slot_index);
    assign idx_ok = ({28'd0, item_reg.slot_index} < 32'(TASK_SLOTS));
    assign prio_fix = (item_reg.slot_priority == 7'd0) ? 7'd1 : item_reg.slot_priority;
    assign wake_new = item_reg.now_ms
                    + (32'(item_reg.sleep_seconds) * 32'(MS_PER_SECOND));

    always_comb
    begin
        op_run_sel = 1'b0;
        unique case (item_reg.operation)
            OP_TICK:  op_run_sel = cur_present && (counter_reg[cur] <= 8'd1);
            OP_SLEEP: op_run_sel = 1'b1;
            OP_SCHED: op_run_sel = 1'b1;
            default:  op_run_sel = 1'b0;
        endcase
    end

    assign woke = !cmd.recharge && present_reg[scan_reg]
               && (status_reg[scan_reg] != ST_EXITED)
               && (item_reg.now_ms > wake_reg[scan_reg]);
    assign eff_status = woke ? ST_RUNNING : status_reg[scan_reg];
    assign cnt_eff = cmd.recharge
                   ? 8'({1'b0, prio_reg[scan_reg]} + {1'b0, counter_reg[scan_reg][7:1]})
                   : counter_reg[scan_reg];
    assign cand = present_reg[scan_reg] && (eff_status == ST_RUNNING)
               && (!pick_valid_reg || (cnt_eff > top_reg));

    assign final_pick = pick_valid_reg ? pick_reg : '0;
    assign final_sw = run_sel_reg && present_reg[final_pick];

    assign stat.run_sel = op_run_sel;
    assign stat.scan_last = (scan_reg == SLOT_W'(TASK_SLOTS - 1));
    assign stat.need_recharge = pick_valid_reg && (top_reg == 8'd0);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.do_op)
        begin
            unique case (item_reg.operation)
                OP_TICK:
                begin
                    if (cur_present)
                    begin
                        counter_reg[cur] <= (counter_reg[cur] > 8'd1)
                                          ? counter_reg[cur] - 8'd1 : 8'd0;
                    end
                end
                OP_SLEEP:
                begin
                    if (cur_present)
                    begin
                        wake_reg[cur] <= wake_new;
                        status_reg[cur] <= ST_SLEEPING;
                    end
                end
                OP_CREATE:
                begin
                    if (idx_ok)
                    begin
                        status_reg[idx] <= ST_RUNNING;
                        prio_reg[idx] <= prio_fix;
                        counter_reg[idx] <= {1'b0, prio_fix};
                        wake_reg[idx] <= 32'd0;
                    end
                end
                OP_EXIT:
                begin
                    if (idx_ok)
                    begin
                        status_reg[idx] <= ST_EXITED;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.scan)
        begin
            if (woke)
            begin
                status_reg[scan_reg] <= ST_RUNNING;
            end
            if (cmd.recharge && present_reg[scan_reg])
            begin
                counter_reg[scan_reg] <= cnt_eff;
            end
        end
        if (cmd.clear)
        begin
            top_reg <= 8'd0;
        end
        else if (cmd.scan && cand)
        begin
            top_reg <= cnt_eff;
            pick_reg <= scan_reg;
        end
        if (cmd.finish)
        begin
            result_reg.scheduled <= run_sel_reg;
            result_reg.switched <= final_sw;
            result_reg.chosen_slot <= run_sel_reg ? 4'(final_pick) : 4'd0;
            result_reg.current_slot <= final_sw ? 4'(final_pick) : 4'(running_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            running_reg <= '0;
            scan_reg <= '0;
            pick_valid_reg <= 1'b0;
            run_sel_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.do_op)
            begin
                run_sel_reg <= op_run_sel;
                if ((item_reg.operation == OP_CREATE) && idx_ok)
                begin
                    present_reg[idx] <= 1'b1;
                end
            end
            if (cmd.clear)
            begin
                scan_reg <= '0;
                pick_valid_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                scan_reg <= scan_reg + SLOT_W'(1);
                if (cand)
                begin
                    pick_valid_reg <= 1'b1;
                end
            end
            if (cmd.finish && final_sw)
            begin
                running_reg <= final_pick;
            end
        end
    end

    assign done = done_reg;
    assign result = result_reg;

endmodule

### src/counter_priority_task_scheduler_core.sv
// ----------------------------------------------------------------------------
// Counter priority task scheduler core
// Time-slice counter scheduler over a table of task slots.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// item      in         start high, busy low  in_item_t
// result    out        done, one cycle       out_result_t
//
// Create, exit and ticks without selection go from the operation state straight
// to finish. Selection adds a scan of the slot table and a decide state, plus one
// more scan when every running counter is zero; a scan counter walks the table.
// Reset clears the present flags and the current slot; done cannot be stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module counter_priority_task_scheduler_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  cpts_pkg::in_item_t    item,
    output logic                  done,
    output cpts_pkg::out_result_t result
);
    import cpts_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t stat;

    cpts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    cpts_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .done   (done),
        .result (result)
    );

endmodule

### src/cpts_checker.sv
// ----------------------------------------------------------------------------
// Scheduler checker
// Port-level assertions on the scheduler core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "counter_priority_task_scheduler_core_macros.svh"
module cpts_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  done,
    input cpts_pkg::out_result_t result
);
    import cpts_pkg::*;

    `CPTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `CPTS_ASSERT_NEVER(a_done_idle, done && busy)
    `CPTS_ASSERT_IMPLY(a_no_sel_no_switch, done && !result.scheduled, !result.switched)
    `CPTS_ASSERT_IMPLY(a_no_sel_chosen, done && !result.scheduled, result.chosen_slot == 4'd0)
    `CPTS_ASSERT_IMPLY(a_switch_current, done && result.switched,
        result.current_slot == result.chosen_slot)

endmodule

bind counter_priority_task_scheduler_core cpts_checker u_cpts_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Scheduler core testbench
// Drives task-table operations into the scheduler core, tracks slot state and
// the current task to predict every result, and compares each field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
    import cpts_pkg::*;

    class sched_scoreboard;
        bit                present [TASK_SLOTS];
        slot_status_e      status [TASK_SLOTS];
        logic [7:0]        counter [TASK_SLOTS];
        logic [6:0]        prio [TASK_SLOTS];
        logic [31:0]       wake_ms [TASK_SLOTS];
        logic [3:0]        cur_slot;
        out_result_t       pending [$];
        int                errors;

        function new();
            for (int i = 0; i < TASK_SLOTS; i++)
            begin
                present[i] = 0;
                status[i] = ST_RUNNING;
                counter[i] = '0;
                prio[i] = '0;
                wake_ms[i] = '0;
            end
            cur_slot = '0;
            errors = 0;
        endfunction

        function int best_running(output logic [7:0] best);
            int pick;
            pick = -1;
            best = '0;
            for (int i = 0; i < TASK_SLOTS; i++)
            begin
                if (present[i] && status[i] == ST_RUNNING && (pick < 0 || counter[i] > best))
                begin
                    best = counter[i];
                    pick = i;
                end
            end
            return pick;
        endfunction

        function void run_selection(input logic [31:0] now, ref out_result_t e);
            int pick;
            logic [7:0] best;
            for (int i = 0; i < TASK_SLOTS; i++)
                if (present[i] && status[i] != ST_EXITED && now > wake_ms[i])
                    status[i] = ST_RUNNING;
            pick = best_running(best);
            if (pick >= 0 && best == 0)
            begin
                for (int i = 0; i < TASK_SLOTS; i++)
                    if (present[i])
                        counter[i] = 8'({1'b0, prio[i]} + (counter[i] >> 1));
                pick = best_running(best);
            end
            if (pick < 0)
                pick = 0;
            e.scheduled = 1'b1;
            e.chosen_slot = 4'(pick);
            if (present[pick])
            begin
                cur_slot = 4'(pick);
                e.switched = 1'b1;
            end
        endfunction

        function void note_item(input in_item_t it);
            out_result_t e;
            logic sel;
            logic [6:0] p;
            e = '0;
            sel = 1'b0;
            case (it.operation)
                OP_TICK:
                    if (present[cur_slot])
                    begin
                        if (counter[cur_slot] > 1)
                            counter[cur_slot] = counter[cur_slot] - 8'd1;
                        else
                        begin
                            counter[cur_slot] = '0;
                            sel = 1'b1;
                        end
                    end
                OP_SLEEP:
                begin
                    if (present[cur_slot])
                    begin
                        wake_ms[cur_slot] = it.now_ms + 32'(it.sleep_seconds) * 32'(MS_PER_SECOND);
                        status[cur_slot] = ST_SLEEPING;
                    end
                    sel = 1'b1;
                end
                OP_CREATE:
                begin
                    p = (it.slot_priority == 0) ? 7'd1 : it.slot_priority;
                    present[it.slot_index] = 1;
                    status[it.slot_index] = ST_RUNNING;
                    prio[it.slot_index] = p;
                    counter[it.slot_index] = {1'b0, p};
                    wake_ms[it.slot_index] = '0;
                end
                OP_EXIT:
                    status[it.slot_index] = ST_EXITED;
                OP_SCHED:
                    sel = 1'b1;
                default:
                    ;
            endcase
            if (sel)
                run_selection(it.now_ms, e);
            e.current_slot = cur_slot;
            pending.push_back(e);
        endfunction

        function void check_result(input out_result_t r);
            out_result_t e;
            if (pending.size() == 0)
            begin
                $error("result with nothing expected: %h", r);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (r.scheduled !== e.scheduled)
            begin
                $error("scheduled: expected %0d, actual %0d", e.scheduled, r.scheduled);
                errors++;
            end
            if (r.switched !== e.switched)
            begin
                $error("switched: expected %0d, actual %0d", e.switched, r.switched);
                errors++;
            end
            if (r.chosen_slot !== e.chosen_slot)
            begin
                $error("chosen_slot: expected %0d, actual %0d", e.chosen_slot, r.chosen_slot);
                errors++;
            end
            if (r.current_slot !== e.current_slot)
            begin
                $error("current_slot: expected %0d, actual %0d", e.current_slot, r.current_slot);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_item_t    item;
    logic        done;
    out_result_t result;

    sched_scoreboard sb;
    int          idle_pct;
    logic [31:0] clock_ms;

    counter_priority_task_scheduler_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_item(item);
            if (done)
                sb.check_result(result);
        end
    end

    task send_item(input in_item_t it);
        int gap;
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task send_op(input logic [2:0] op, input logic [31:0] now, input logic [15:0] secs,
                 input logic [3:0] idx, input logic [6:0] pr);
        in_item_t it;
        it.operation = op;
        it.now_ms = now;
        it.sleep_seconds = secs;
        it.slot_index = idx;
        it.slot_priority = pr;
        send_item(it);
    endtask

    task send_random;
        int r;
        logic [6:0] pr;
        logic [15:0] secs;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 2)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + 32'd10;
        pr = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(1, 127)) : 7'($urandom_range(1, 12));
        secs = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
        if (r < 62)
            send_op(OP_TICK, clock_ms, 16'($urandom), 4'($urandom), pr);
        else if (r < 72)
            send_op(OP_SLEEP, clock_ms, secs, 4'($urandom), pr);
        else if (r < 84)
            send_op(OP_CREATE, clock_ms, 16'($urandom), 4'($urandom), pr);
        else if (r < 90)
            send_op(OP_EXIT, clock_ms, 16'($urandom), 4'($urandom), pr);
        else
            send_op(OP_SCHED, clock_ms, 16'($urandom), 4'($urandom), pr);
    endtask

    initial
    begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int waited;
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        idle_pct = 0;
        clock_ms = 32'd1000;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_op(OP_TICK, 32'd0, 16'd0, 4'd0, 7'd1);
        send_op(OP_SLEEP, 32'd5, 16'd1, 4'd0, 7'd1);
        send_op(OP_SCHED, 32'd6, 16'd0, 4'd0, 7'd1);
        send_op(OP_EXIT, 32'd7, 16'd0, 4'd7, 7'd1);
        send_op(OP_CREATE, 32'd8, 16'd0, 4'd0, 7'd127);
        send_op(OP_CREATE, 32'd9, 16'd0, 4'd15, 7'd1);
        send_op(OP_CREATE, 32'd10, 16'd0, 4'd3, 7'd0);
        send_op(OP_SCHED, 32'd11, 16'd0, 4'd0, 7'd1);
        send_op(OP_TICK, 32'd12, 16'd0, 4'd0, 7'd1);
        send_op(OP_TICK, 32'd13, 16'd0, 4'd0, 7'd1);
        send_op(OP_SLEEP, 32'hFFFF_FFF0, 16'hFFFF, 4'd0, 7'd1);
        send_op(OP_SCHED, 32'hFFFF_FFFF, 16'd0, 4'd0, 7'd1);
        send_op(OP_EXIT, 32'd20, 16'd0, 4'd15, 7'd1);
        send_op(OP_TICK, 32'd30, 16'd0, 4'd0, 7'd1);
        send_op(OP_TICK, 32'd40, 16'd0, 4'd0, 7'd1);
        send_op(3'd5, 32'd50, 16'd0, 4'd2, 7'd5);
        send_op(3'd7, 32'd60, 16'd0, 4'd2, 7'd5);
        send_op(OP_SLEEP, 32'd70, 16'd0, 4'd0, 7'd1);
        send_op(OP_SCHED, 32'd0, 16'd0, 4'd0, 7'd1);
        send_op(OP_SCHED, 32'd80, 16'd0, 4'd0, 7'd1);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: idle_pct = 0;
                1: idle_pct = 82;
                2: idle_pct = 31;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < 385; n++)
                send_random();
        end
        start <= 1'b0;

        waited = 0;
        while (sb.pending.size() != 0 && waited < 10000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (2 * TASK_SLOTS + 10) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
